// File: src/sha2_pkg.sv
// sha2_pkg: shared types, constants and round functions for the SHA-256/SHA-224 hasher.
// Used by sha256_224_hash_top; no dependencies.

package sha2_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int CHAIN_WORDS = 8;
    localparam int ROUNDS      = 64;
    localparam int COUNT_W     = 61;
    localparam int WADDR_W     = $clog2(BLOCK_WORDS);
    localparam int ROUND_W     = $clog2(ROUNDS);

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_INIT,
        ST_PAD_FILL,
        ST_CMP,
        ST_CMP_ADD,
        ST_OUT
    } state_t;

    // Six steps per compression round through the single read port
    typedef enum logic [2:0] {
        PH_ADDR0,
        PH_W16,
        PH_W15,
        PH_W7,
        PH_SCHED,
        PH_ROUND
    } phase_t;

    // Where the sequencer goes once a compression is folded into the chain
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD_START,
        RET_PAD_TAIL,
        RET_DIGEST
    } ret_t;

    localparam logic [7:0]         PAD_BYTE      = 8'h80;
    localparam logic [5:0]         BYTE_POS_LAST = 6'h3F;
    localparam logic [WADDR_W-1:0] LEN_HI_IDX    = 4'd14;
    localparam logic [WADDR_W-1:0] LEN_LO_IDX    = 4'd15;
    localparam logic [WADDR_W-1:0] OFF_W15       = 4'd1;
    localparam logic [WADDR_W-1:0] OFF_W7        = 4'd9;
    localparam logic [WADDR_W-1:0] OFF_W2        = 4'd14;
    localparam logic [2:0]         LAST_IDX_256  = 3'd7;
    localparam logic [2:0]         LAST_IDX_224  = 3'd6;

    localparam word_t IV256 [CHAIN_WORDS] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam word_t IV224 [CHAIN_WORDS] = '{
        32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
        32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t bsig0(input word_t a);
        return rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    endfunction

    function automatic word_t bsig1(input word_t e);
        return rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    endfunction

    function automatic word_t ssig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t ch(input word_t e, input word_t f, input word_t g);
        return g ^ (e & (f ^ g));
    endfunction

    function automatic word_t maj(input word_t a, input word_t b, input word_t c);
        return (a & b) | (c & (a | b));
    endfunction

    // Drop a byte into its big-endian lane of a word
    function automatic word_t put_lane(input word_t w, input logic [1:0] lane,
                                       input logic [7:0] b);
        word_t r;
        r = w;
        unique case (lane)
            2'd0: r[31:24] = b;
            2'd1: r[23:16] = b;
            2'd2: r[15:8]  = b;
            2'd3: r[7:0]   = b;
        endcase
        return r;
    endfunction

    // Keep lanes before the pad lane, put the pad marker, zero the rest
    function automatic word_t pad_word(input word_t w, input logic [1:0] lane);
        word_t r;
        unique case (lane)
            2'd0: r = {PAD_BYTE, 24'h000000};
            2'd1: r = {w[31:24], PAD_BYTE, 16'h0000};
            2'd2: r = {w[31:16], PAD_BYTE, 8'h00};
            2'd3: r = {w[31:8], PAD_BYTE};
        endcase
        return r;
    endfunction

endpackage

// File: src/sha2_ram.sv
// sha2_ram: generic single-write, single-read synchronous RAM with registered read.
// Standalone; no package dependency.

module sha2_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/sha256_224_hash_top.sv
// sha256_224_hash_top: byte-streaming SHA-256 / SHA-224 hasher.
// Depends on sha2_pkg and sha2_ram.

// Feed the message one word per handshake on the item channel: data_byte with has_byte set
// carries a byte, end_of_message closes the message (a byte in the same word is absorbed
// first; an end word with no byte allows the empty message). Bytes are taken one per cycle
// while the block store fills. The sixteen message words and, during compression, the
// rolling message schedule live in one 16 x 32 RAM with one read and one write port; each
// of the 64 rounds runs four schedule reads, the schedule add and the round update, and a
// full 64-byte block holds item_ready low through all 64 rounds and the chain add.
// At end of message the block takes a setup step and then writes each padded word, then
// one or two compressions (two when fewer than nine bytes remain in the final block), then
// eight digest words (seven in SHA-224 mode) go out one per cycle as digest_ready
// allows, word 0 first, last_word on the final one. The digest register parts the two
// sides: the next message can start while the final digest word still waits. A write on
// the configuration port selects the mode and restarts the message; issue it only while
// the hasher is idle.

module sha256_224_hash_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             cfg_data,
    input  logic             item_valid,
    output logic             item_ready,
    input  logic [7:0]       data_byte,
    input  logic             has_byte,
    input  logic             end_of_message,
    output logic             digest_valid,
    input  logic             digest_ready,
    output sha2_pkg::word_t  digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    import sha2_pkg::*;

    // Sequencer and control
    state_t                 state_reg,   state_next;
    phase_t                 phase_reg,   phase_next;
    ret_t                   ret_reg,     ret_next;
    logic [ROUND_W-1:0]     round_reg,   round_next;
    logic [COUNT_W-1:0]     count_reg,   count_next;
    logic                   mode_reg,    mode_next;
    logic                   first_reg,   first_next;
    logic                   lenblk_reg,  lenblk_next;
    logic [WADDR_W-1:0]     pad_idx_reg, pad_idx_next;
    logic [2:0]             out_idx_reg, out_idx_next;

    // Hash state and datapath
    word_t                  chain_reg [CHAIN_WORDS];
    word_t                  chain_next [CHAIN_WORDS];
    word_t                  v_reg [CHAIN_WORDS];
    word_t                  v_next [CHAIN_WORDS];
    word_t                  w_reg,  w_next;
    word_t                  d0_reg, d0_next;
    word_t                  d1_reg, d1_next;
    word_t                  d2_reg, d2_next;
    word_t                  acc_reg, acc_next;

    // Digest output register
    logic                   out_valid_reg, out_valid_next;
    word_t                  out_word_reg,  out_word_next;
    logic [2:0]             out_index_reg, out_index_next;
    logic                   out_last_reg,  out_last_next;

    // Block store port
    logic                   ram_we;
    logic [WADDR_W-1:0]     ram_waddr;
    word_t                  ram_wdata;
    logic [WADDR_W-1:0]     ram_raddr;
    word_t                  ram_rdata;

    logic                   item_fire;
    logic                   out_free;
    logic [2:0]             last_idx;

    sha2_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLOCK_WORDS)
    ) u_block_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign item_fire  = item_valid && item_ready;
    assign out_free   = !out_valid_reg || digest_ready;
    assign last_idx   = mode_reg ? LAST_IDX_224 : LAST_IDX_256;

    always_comb
    begin
        word_t t1;
        word_t t2;
        logic  load_v;

        state_next     = state_reg;
        phase_next     = phase_reg;
        ret_next       = ret_reg;
        round_next     = round_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        first_next     = first_reg;
        lenblk_next    = lenblk_reg;
        pad_idx_next   = pad_idx_reg;
        out_idx_next   = out_idx_reg;
        chain_next     = chain_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !digest_ready;
        out_word_next  = out_word_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = round_reg[WADDR_W-1:0];
        ram_wdata      = w_reg;
        ram_raddr      = round_reg[WADDR_W-1:0];
        load_v         = 1'b0;
        t1             = '0;
        t2             = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (has_byte)
                    begin
                        // Pack the byte; write the word back once its last lane fills
                        acc_next   = put_lane(acc_reg, count_reg[1:0], data_byte);
                        count_next = count_reg + COUNT_W'(1);
                        if (count_reg[1:0] == 2'b11)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = count_reg[5:2];
                            ram_wdata = acc_next;
                        end
                        if (count_reg[5:0] == BYTE_POS_LAST)
                        begin
                            state_next = ST_CMP;
                            load_v     = 1'b1;
                            ret_next   = end_of_message ? RET_PAD_START : RET_IDLE;
                        end
                        else if (end_of_message)
                        begin
                            state_next = ST_PAD_INIT;
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD_INIT;
                    end
                end
            end

            ST_PAD_INIT:
            begin
                // Length fits in this block only if the marker lands before byte 56
                pad_idx_next = count_reg[5:2];
                first_next   = 1'b1;
                lenblk_next  = (count_reg[5:3] != 3'b111);
                state_next   = ST_PAD_FILL;
            end

            ST_PAD_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = pad_idx_reg;
                if (first_reg)
                begin
                    ram_wdata = pad_word(acc_reg, count_reg[1:0]);
                end
                else if (lenblk_reg && (pad_idx_reg == LEN_HI_IDX))
                begin
                    ram_wdata = count_reg[COUNT_W-1:29];
                end
                else if (lenblk_reg && (pad_idx_reg == LEN_LO_IDX))
                begin
                    ram_wdata = {count_reg[28:0], 3'b000};
                end
                else
                begin
                    ram_wdata = '0;
                end
                first_next = 1'b0;
                if (pad_idx_reg == LEN_LO_IDX)
                begin
                    state_next = ST_CMP;
                    load_v     = 1'b1;
                    ret_next   = lenblk_reg ? RET_DIGEST : RET_PAD_TAIL;
                end
                else
                begin
                    pad_idx_next = pad_idx_reg + WADDR_W'(1);
                end
            end

            ST_CMP:
            begin
                unique case (phase_reg)
                    PH_ADDR0:
                    begin
                        ram_raddr  = round_reg[WADDR_W-1:0];
                        phase_next = PH_W16;
                    end
                    PH_W16:
                    begin
                        d0_next    = ram_rdata;
                        ram_raddr  = round_reg[WADDR_W-1:0] + OFF_W15;
                        phase_next = PH_W15;
                    end
                    PH_W15:
                    begin
                        d1_next    = ram_rdata;
                        ram_raddr  = round_reg[WADDR_W-1:0] + OFF_W7;
                        phase_next = PH_W7;
                    end
                    PH_W7:
                    begin
                        d2_next    = ram_rdata;
                        ram_raddr  = round_reg[WADDR_W-1:0] + OFF_W2;
                        phase_next = PH_SCHED;
                    end
                    PH_SCHED:
                    begin
                        // First sixteen rounds use the block word as is
                        if (round_reg[ROUND_W-1:WADDR_W] == '0)
                        begin
                            w_next = d0_reg;
                        end
                        else
                        begin
                            w_next = ssig1(ram_rdata) + d2_reg + ssig0(d1_reg) + d0_reg;
                        end
                        ram_we     = 1'b1;
                        ram_waddr  = round_reg[WADDR_W-1:0];
                        ram_wdata  = w_next;
                        phase_next = PH_ROUND;
                    end
                    PH_ROUND:
                    begin
                        t1 = v_reg[7] + bsig1(v_reg[4]) + ch(v_reg[4], v_reg[5], v_reg[6])
                           + ROUND_K[round_reg] + w_reg;
                        t2 = bsig0(v_reg[0]) + maj(v_reg[0], v_reg[1], v_reg[2]);
                        v_next[7] = v_reg[6];
                        v_next[6] = v_reg[5];
                        v_next[5] = v_reg[4];
                        v_next[4] = v_reg[3] + t1;
                        v_next[3] = v_reg[2];
                        v_next[2] = v_reg[1];
                        v_next[1] = v_reg[0];
                        v_next[0] = t1 + t2;
                        round_next = round_reg + ROUND_W'(1);
                        phase_next = PH_ADDR0;
                        if (round_reg == ROUND_W'(ROUNDS - 1))
                        begin
                            state_next = ST_CMP_ADD;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_ADDR0;
                    end
                endcase
            end

            ST_CMP_ADD:
            begin
                for (int k = 0; k < CHAIN_WORDS; k++)
                begin
                    chain_next[k] = chain_reg[k] + v_reg[k];
                end
                unique case (ret_reg)
                    RET_IDLE:
                    begin
                        state_next = ST_IDLE;
                    end
                    RET_PAD_START:
                    begin
                        state_next = ST_PAD_INIT;
                    end
                    RET_PAD_TAIL:
                    begin
                        pad_idx_next = '0;
                        first_next   = 1'b0;
                        lenblk_next  = 1'b1;
                        state_next   = ST_PAD_FILL;
                    end
                    RET_DIGEST:
                    begin
                        out_idx_next = '0;
                        state_next   = ST_OUT;
                    end
                endcase
            end

            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = chain_reg[out_idx_reg];
                    out_index_next = out_idx_reg;
                    out_last_next  = (out_idx_reg == last_idx);
                    if (out_idx_reg == last_idx)
                    begin
                        // Reload initial values for the next message
                        for (int k = 0; k < CHAIN_WORDS; k++)
                        begin
                            chain_next[k] = mode_reg ? IV224[k] : IV256[k];
                        end
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_v)
        begin
            v_next     = chain_reg;
            round_next = '0;
            phase_next = PH_ADDR0;
        end

        // Mode write restarts the message with the new initial values
        if (cfg_write)
        begin
            mode_next  = cfg_data;
            for (int k = 0; k < CHAIN_WORDS; k++)
            begin
                chain_next[k] = cfg_data ? IV224[k] : IV256[k];
            end
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_ADDR0;
            ret_reg       <= RET_IDLE;
            round_reg     <= '0;
            count_reg     <= '0;
            mode_reg      <= 1'b0;
            first_reg     <= 1'b0;
            lenblk_reg    <= 1'b0;
            pad_idx_reg   <= '0;
            out_idx_reg   <= '0;
            chain_reg     <= IV256;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            ret_reg       <= ret_next;
            round_reg     <= round_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            first_reg     <= first_next;
            lenblk_reg    <= lenblk_next;
            pad_idx_reg   <= pad_idx_next;
            out_idx_reg   <= out_idx_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        w_reg         <= w_next;
        d0_reg        <= d0_next;
        d1_reg        <= d1_next;
        d2_reg        <= d2_next;
        acc_reg       <= acc_next;
        out_word_reg  <= out_word_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    assign digest_valid = out_valid_reg;
    assign digest_word  = out_word_reg;
    assign word_index   = out_index_reg;
    assign last_word    = out_last_reg;

`ifndef SYNTHESIS
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && last_word |-> word_index == last_idx)
        else $error("last digest word at wrong index");

    a_round_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_CMP |-> round_reg == '0 && phase_reg == PH_ADDR0)
        else $error("round sequencer active outside compression");

    a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && has_byte && count_reg[5:0] == BYTE_POS_LAST |=> state_reg == ST_CMP)
        else $error("full block did not start compression");

    a_words_follow: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && !last_word |=> digest_valid)
        else $error("gap inside digest word sequence");
`endif

endmodule
